### rtl/core/peer_address_table_with_aging_top_assert.svh
// Assertion macros for the checker of the peer address table.
`ifndef PEER_ADDRESS_TABLE_WITH_AGING_TOP_ASSERT_SVH
`define PEER_ADDRESS_TABLE_WITH_AGING_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PAT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("peer table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PAT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("peer table check failed");

`endif

### rtl/core/pat_pkg.sv
package pat_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = 48;
    localparam int TIME_W      = 48;
    localparam int THR_W       = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 48;

    localparam logic [THR_W-1:0] THR_RESET = 32'd10000;

    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_MAC      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_THRESHOLD = 1'd1;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_SEEN   = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_IGNORED   = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    // Commands broadcast from the sequencer to every cell.
    typedef struct packed {
        logic capture;
        logic shift_up;
        logic remove;
        logic refresh;
    } cell_ctl_t;

endpackage

### rtl/core/pat_cell.sv
module pat_cell
    import pat_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctl_t         ctl,
    input  logic              live,
    input  logic [ADDR_W-1:0] req_mac,
    input  logic [TIME_W-1:0] req_now,
    input  entry_t            left_in,
    input  entry_t            right_in,
    input  logic              after_in,
    output entry_t            entry_out,
    output logic              match_out,
    output logic              after_out
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   match_reg;

    // A cell at or beyond the removed entry takes its right neighbor's word.
    assign after_out = after_in | match_reg;
    assign entry_out = entry_reg;
    assign match_out = match_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.shift_up) begin
            entry_next = left_in;
        end else if (ctl.remove && after_out) begin
            entry_next = right_in;
        end else if (ctl.refresh && match_reg) begin
            entry_next.stamp = req_now;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (ctl.capture) begin
            match_reg <= live && (entry_reg.addr == req_mac);
        end
    end

endmodule

### rtl/core/peer_address_table_with_aging_top.sv
// Peer address table with aging: up to MAX_ENTRIES peer addresses, each with a
// last-seen time stamp, held in a row of cells that compare in parallel.
// The request channel (s_valid/s_ready) carries one word per request: the
// operation in s_kind (add, remove, seen refresh, range query), the address
// in s_mac and the current time in s_now_ms. The result channel
// (m_valid/m_ready) returns exactly one word per request with status, found,
// in_range and the live entry count after the request.
// A request passes through four steps: accept, a compare in every cell, the
// update step that shifts or refreshes the cells, and the age check into the
// output register. The four-step sequencer takes a new request only once it
// has returned to idle, after the result is loaded into the output register.
// When the receiver stalls, the finished word waits in the output register
// while the next request is accepted and processed; that request then waits
// in its final step until the output register is free.
// Reset (aresetn low, synchronous) empties the table, clears the own address
// and sets the stale threshold to 10000 ms. The user must write the configuration
// port with cfg_we, cfg_index and cfg_wdata only while idle; the block does not enforce it.
module peer_address_table_with_aging_top
    import pat_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic [ADDR_W-1:0]     s_mac,
    input  logic [TIME_W-1:0]     s_now_ms,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic                  m_found,
    output logic                  m_in_range,
    output logic [COUNT_OUT_W-1:0] m_count
);

    typedef enum logic [3:0] {
        SEQ_IDLE = 4'b0001,
        SEQ_LOOK = 4'b0010,
        SEQ_EXEC = 4'b0100,
        SEQ_DONE = 4'b1000
    } seq_t;

    seq_t                 state_reg, state_next;
    logic [ADDR_W-1:0]    device_mac_reg;
    logic [THR_W-1:0]     thr_reg;
    logic [CNT_W-1:0]     count_reg, count_next;

    // Request and intermediate results of the word in flight.
    kind_t                kind_reg;
    logic [ADDR_W-1:0]    req_mac_reg;
    logic [TIME_W-1:0]    req_now_reg;
    logic                 own_reg;
    logic                 hit_reg;
    status_t              status_reg, status_next;
    logic [TIME_W-1:0]    age_reg;

    // Output register.
    logic                 m_valid_reg;
    status_t              m_status_reg;
    logic                 m_found_reg;
    logic                 m_in_range_reg;
    logic [COUNT_OUT_W-1:0] m_count_reg;

    cell_ctl_t              ctl;
    entry_t                 cell_entry [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES:0]   after_chain;
    entry_t                 new_entry;
    logic [TIME_W-1:0]      sel_stamp;
    logic                   hit;
    logic                   full;
    logic                   fresh;
    logic                   out_load;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    assign s_ready  = (state_reg == SEQ_IDLE);
    assign out_load = (state_reg == SEQ_DONE) && (!m_valid_reg || m_ready);

    // The new entry enters at the head of the row; all others move up by one.
    assign new_entry.addr  = req_mac_reg;
    assign new_entry.stamp = req_now_reg;
    assign after_chain[0]  = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
            localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(gi);
            entry_t left_w;
            entry_t right_w;

            if (gi == 0) begin : g_head
                assign left_w = new_entry;
            end else begin : g_body
                assign left_w = cell_entry[gi-1];
            end

            // The last cell never keeps a live word after a removal, so it
            // can reload itself.
            if (gi == MAX_ENTRIES - 1) begin : g_tail
                assign right_w = cell_entry[gi];
            end else begin : g_inner
                assign right_w = cell_entry[gi+1];
            end

            pat_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .live      (CELL_IDX < count_reg),
                .req_mac   (req_mac_reg),
                .req_now   (req_now_reg),
                .left_in   (left_w),
                .right_in  (right_w),
                .after_in  (after_chain[gi]),
                .entry_out (cell_entry[gi]),
                .match_out (match_vec[gi]),
                .after_out (after_chain[gi+1])
            );
        end
    endgenerate

    // Addresses in the table are unique, so at most one cell matches and the
    // stamp select is a plain AND-OR over the cells.
    always_comb begin
        sel_stamp = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            sel_stamp = sel_stamp | (match_vec[i] ? cell_entry[i].stamp : '0);
        end
    end

    assign hit  = |match_vec;
    assign full = (count_reg == CNT_W'(MAX_ENTRIES));

    // Decision step: one status per request and the cell command that goes
    // with it.
    always_comb begin
        ctl         = '0;
        ctl.capture = (state_reg == SEQ_LOOK);
        status_next = STATUS_DONE;
        count_next  = count_reg;
        case (kind_reg)
            KIND_ADD: begin
                if (hit || own_reg) begin
                    status_next = STATUS_IGNORED;
                end else if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    ctl.shift_up = (state_reg == SEQ_EXEC);
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            KIND_REMOVE: begin
                if (hit) begin
                    ctl.remove = (state_reg == SEQ_EXEC);
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            KIND_SEEN: begin
                if (own_reg) begin
                    status_next = STATUS_IGNORED;
                end else if (hit) begin
                    ctl.refresh = (state_reg == SEQ_EXEC);
                end else begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            KIND_QUERY: begin
                if (!hit) begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            default: begin
                status_next = STATUS_DONE;
            end
        endcase
    end

    // The age is below a 32-bit threshold only when its upper bits are zero.
    assign fresh = hit_reg && (kind_reg == KIND_QUERY)
                && (age_reg[TIME_W-1:THR_W] == '0)
                && (age_reg[THR_W-1:0] < thr_reg);

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: begin
                if (s_valid) begin
                    state_next = SEQ_LOOK;
                end
            end
            SEQ_LOOK: begin
                state_next = SEQ_EXEC;
            end
            SEQ_EXEC: begin
                state_next = SEQ_DONE;
            end
            SEQ_DONE: begin
                if (out_load) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SEQ_IDLE;
            count_reg      <= '0;
            device_mac_reg <= '0;
            thr_reg        <= THR_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == SEQ_EXEC) begin
                count_reg <= count_next;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_DEVICE_MAC:      device_mac_reg <= cfg_wdata[ADDR_W-1:0];
                    REG_STALE_THRESHOLD: thr_reg        <= cfg_wdata[THR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg    <= kind_t'(s_kind);
            req_mac_reg <= s_mac;
            req_now_reg <= s_now_ms;
        end
        if (state_reg == SEQ_LOOK) begin
            own_reg <= (req_mac_reg == device_mac_reg);
        end
        if (state_reg == SEQ_EXEC) begin
            hit_reg    <= hit;
            status_reg <= status_next;
            age_reg    <= req_now_reg - sel_stamp;
        end
        if (out_load) begin
            m_status_reg   <= status_reg;
            m_found_reg    <= hit_reg;
            m_in_range_reg <= fresh;
            m_count_reg    <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_found    = m_found_reg;
    assign m_in_range = m_in_range_reg;
    assign m_count    = m_count_reg;

endmodule

### rtl/core/pat_checker.sv
`include "peer_address_table_with_aging_top_assert.svh"

module pat_checker
    import pat_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [1:0]             m_status,
    input logic                   m_found,
    input logic                   m_in_range,
    input logic [COUNT_OUT_W-1:0] m_count
);

    // One request at a time: the input closes right after an acceptance.
    `PAT_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A fresh peer is always a known peer with a completed query.
    `PAT_ASSERT_NOW(a_range_needs_hit, aclk, aresetn, m_valid && m_in_range,
        m_found && (m_status == STATUS_DONE))

    // A missing address never reports found.
    `PAT_ASSERT_NOW(a_not_found_clean, aclk, aresetn,
        m_valid && (m_status == STATUS_NOT_FOUND), !m_found)

    // A stalled result word holds.
    `PAT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_count))

endmodule

bind peer_address_table_with_aging_top pat_checker u_pat_checker (.*);
